// ----- design/tile_row_run_length_packer_assert.svh -----
// Assertion macros shared by the tile row run-length packer modules
`ifndef TILE_ROW_RUN_LENGTH_PACKER_ASSERT_SVH
`define TILE_ROW_RUN_LENGTH_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TRLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TRLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/trlp_pkg.sv -----
// Shared constants and types of the tile row run-length packer
`timescale 1ns / 1ps
package trlp_pkg;

    localparam int TILE_W    = 32;
    localparam int TILE_H    = 16;
    localparam int BYTE_W    = 8;
    localparam int OFS_W     = 10;
    localparam int COL_W     = $clog2(TILE_W);
    localparam int LEN_W     = $clog2(TILE_W + 1);
    localparam int ROW_W     = (TILE_H > 1) ? $clog2(TILE_H) : 1;
    localparam int RUN_MAX   = (TILE_W + 1) / 2;
    localparam int RUNS_W    = $clog2(RUN_MAX + 1);
    localparam int RUN_IDX_W = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
    localparam int OUT_TDATA_W = ((BYTE_W + 2 * OFS_W + 7) / 8) * 8;

    // Header byte of a tile with at least one opaque pixel
    localparam logic [BYTE_W-1:0] HDR_OPAQUE = 8'd16;
    localparam logic [BYTE_W-1:0] HDR_EMPTY  = 8'd0;

    // One opaque run of a row, as stored in the run table
    typedef struct packed {
        logic [COL_W-1:0] skip;
        logic [LEN_W-1:0] len;
        logic [COL_W-1:0] start;
    } run_entry_t;

    localparam int RUN_ENTRY_W = $bits(run_entry_t);

    // Row handover from the fill side to the emitter
    typedef struct packed {
        logic              full;
        logic [RUNS_W-1:0] runs;
    } row_info_t;

endpackage

// ----- design/tile_row_run_length_packer.sv -----
// Top level of the tile row run-length packer
//
// Takes a 32x16 tile of 8-bit pixels, bottom row first, one pixel per beat on
// s_axis, and produces the packed run-length stream on m_axis, one byte per
// beat with its stream offset. Per row: run count, then skip, length and the
// literal bytes of each opaque run, at offsets counting up from 1. After the
// last row comes the header at offset 0 with tlast high and the packed length.
// Pixels go into a 32-entry row RAM; runs are found on the fly and written to
// a run table RAM, so the run count is known when the row closes.
// Pixels are taken one per cycle while s_axis_tready is high. After the 32nd
// pixel, s_axis_tready stays low while the row is emitted: S_IDLE picks up the
// full row, S_COUNT sends the run count, S_SKIP, S_LEN and S_LIT the skip,
// length and literal bytes of each run (one byte per cycle while the output is
// free, next RAM read overlapped with the current beat), and S_ROWEND closes the
// row, which on the last row also emits the header. After a row's last pixel
// is taken, S_IDLE passes to S_COUNT, which loads its first byte into the
// output register. When m_axis_tready is low the output register holds its
// beat and the emitter waits; input resumes only once the row's last byte is loaded.
// Reset restores the counters: the next pixel starts a new tile at offset 1.
`timescale 1ns / 1ps
module tile_row_run_length_packer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [trlp_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] pixel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] out_byte, [17:8] offset, [27:18] packed_length, rest zero
    output logic [trlp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import trlp_pkg::*;

    row_info_t              row_info;
    logic                   row_release;
    logic                   row_we;
    logic [COL_W-1:0]       row_waddr;
    logic [BYTE_W-1:0]      row_wdata;
    logic                   row_rd_en;
    logic [COL_W-1:0]       row_raddr;
    logic [BYTE_W-1:0]      row_rdata;
    logic                   tab_we;
    logic [RUN_IDX_W-1:0]   tab_waddr;
    run_entry_t             tab_wdata;
    logic                   tab_rd_en;
    logic [RUN_IDX_W-1:0]   tab_raddr;
    run_entry_t             tab_rdata;
    logic [BYTE_W-1:0]      out_byte;
    logic [OFS_W-1:0]       out_ofs;
    logic [OFS_W-1:0]       out_plen;

    // Collect pixels and runs
    trlp_fill u_fill (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .row_release   (row_release),
        .row_info      (row_info),
        .row_we        (row_we),
        .row_waddr     (row_waddr),
        .row_wdata     (row_wdata),
        .tab_we        (tab_we),
        .tab_waddr     (tab_waddr),
        .tab_wdata     (tab_wdata)
    );

    // Row pixel store
    trlp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TILE_W)
    ) u_row_ram (
        .clk     (clk),
        .we      (row_we),
        .wr_addr (row_waddr),
        .wr_data (row_wdata),
        .rd_en   (row_rd_en),
        .rd_addr (row_raddr),
        .rd_data (row_rdata)
    );

    // Run table of the current row
    trlp_ram #(
        .WIDTH (RUN_ENTRY_W),
        .DEPTH (RUN_MAX)
    ) u_run_ram (
        .clk     (clk),
        .we      (tab_we),
        .wr_addr (tab_waddr),
        .wr_data (tab_wdata),
        .rd_en   (tab_rd_en),
        .rd_addr (tab_raddr),
        .rd_data (tab_rdata)
    );

    // Emit packed bytes
    trlp_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_info    (row_info),
        .row_release (row_release),
        .tab_rd_en   (tab_rd_en),
        .tab_raddr   (tab_raddr),
        .tab_rdata   (tab_rdata),
        .row_rd_en   (row_rd_en),
        .row_raddr   (row_raddr),
        .row_rdata   (row_rdata),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_byte      (out_byte),
        .m_offset    (out_ofs),
        .m_last      (m_axis_tlast),
        .m_plen      (out_plen)
    );

    // Pack the result beat
    assign m_axis_tdata = {{(OUT_TDATA_W - BYTE_W - 2 * OFS_W){1'b0}},
                           out_plen, out_ofs, out_byte};

endmodule

// ----- design/trlp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module trlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word; hold it while rd_en is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/trlp_fill.sv -----
// Input side: stores the row pixels and builds the run table as they arrive
`timescale 1ns / 1ps
`include "tile_row_run_length_packer_assert.svh"
module trlp_fill (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [trlp_pkg::BYTE_W-1:0]        s_axis_tdata,
    input  logic                               row_release,
    output trlp_pkg::row_info_t                row_info,
    output logic                               row_we,
    output logic [trlp_pkg::COL_W-1:0]         row_waddr,
    output logic [trlp_pkg::BYTE_W-1:0]        row_wdata,
    output logic                               tab_we,
    output logic [trlp_pkg::RUN_IDX_W-1:0]     tab_waddr,
    output trlp_pkg::run_entry_t               tab_wdata
);
    import trlp_pkg::*;

    logic                 full_reg,   full_next;
    logic [COL_W-1:0]     col_reg,    col_next;
    logic [RUNS_W-1:0]    runs_reg,   runs_next;
    logic                 in_run_reg, in_run_next;
    logic [COL_W-1:0]     skip_reg,   skip_next;
    logic [COL_W-1:0]     start_reg,  start_next;
    logic [LEN_W-1:0]     len_reg,    len_next;
    logic                 accept;
    logic                 opaque_px;
    logic                 last_col;

    assign accept    = s_axis_tvalid && !full_reg;
    assign opaque_px = (s_axis_tdata != '0);
    assign last_col  = (col_reg == COL_W'(TILE_W - 1));

    assign s_axis_tready = !full_reg;
    assign row_we        = accept;
    assign row_waddr     = col_reg;
    assign row_wdata     = s_axis_tdata;
    assign tab_waddr     = runs_reg[RUN_IDX_W-1:0];
    assign row_info      = '{full: full_reg, runs: runs_reg};

    // Track skip, start and length of the current run; write a run when it closes
    always_comb
    begin
        full_next   = full_reg;
        col_next    = col_reg;
        runs_next   = runs_reg;
        in_run_next = in_run_reg;
        skip_next   = skip_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        tab_we      = 1'b0;
        tab_wdata   = '{skip: skip_reg, len: len_reg, start: start_reg};

        if (row_release)
        begin
            full_next = 1'b0;
            runs_next = '0;
        end
        else if (accept)
        begin
            col_next = last_col ? '0 : col_reg + COL_W'(1);
            if (opaque_px)
            begin
                if (in_run_reg)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    in_run_next = 1'b1;
                    start_next  = col_reg;
                    len_next    = LEN_W'(1);
                end
                if (last_col)
                begin
                    tab_we    = 1'b1;
                    tab_wdata = '{skip: skip_reg, len: len_next, start: start_next};
                    runs_next = runs_reg + RUNS_W'(1);
                end
            end
            else
            begin
                if (in_run_reg)
                begin
                    tab_we      = 1'b1;
                    runs_next   = runs_reg + RUNS_W'(1);
                    in_run_next = 1'b0;
                    skip_next   = COL_W'(1);
                end
                else
                begin
                    skip_next = skip_reg + COL_W'(1);
                end
            end
            // Close the row and hold input until the emitter releases it
            if (last_col)
            begin
                full_next   = 1'b1;
                in_run_next = 1'b0;
                skip_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 1'b0;
            col_reg    <= '0;
            runs_reg   <= '0;
            in_run_reg <= 1'b0;
            skip_reg   <= '0;
        end
        else
        begin
            full_reg   <= full_next;
            col_reg    <= col_next;
            runs_reg   <= runs_next;
            in_run_reg <= in_run_next;
            skip_reg   <= skip_next;
        end
    end

    // Run position and length need no reset
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    `TRLP_ASSERT_NOW(a_tab_in_range, tab_we, runs_reg < RUNS_W'(RUN_MAX),
        "run table written beyond its depth")
    `TRLP_ASSERT_NOW(a_tab_len_nonzero, tab_we, tab_wdata.len != '0,
        "run of zero length written")
    `TRLP_ASSERT_NEXT(a_row_closed_clean, accept && last_col,
        full_reg && col_reg == '0 && !in_run_reg,
        "row not closed after its last pixel")

endmodule

// ----- design/trlp_emit.sv -----
// Output side: walks the run table and the row store and emits the packed bytes
`timescale 1ns / 1ps
`include "tile_row_run_length_packer_assert.svh"
module trlp_emit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  trlp_pkg::row_info_t                row_info,
    output logic                               row_release,
    output logic                               tab_rd_en,
    output logic [trlp_pkg::RUN_IDX_W-1:0]     tab_raddr,
    input  trlp_pkg::run_entry_t               tab_rdata,
    output logic                               row_rd_en,
    output logic [trlp_pkg::COL_W-1:0]         row_raddr,
    input  logic [trlp_pkg::BYTE_W-1:0]        row_rdata,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [trlp_pkg::BYTE_W-1:0]        m_byte,
    output logic [trlp_pkg::OFS_W-1:0]         m_offset,
    output logic                               m_last,
    output logic [trlp_pkg::OFS_W-1:0]         m_plen
);
    import trlp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SKIP,
        S_LEN,
        S_LIT,
        S_ROWEND
    } state_t;

    state_t               state_reg,    state_next;
    logic [RUNS_W-1:0]    run_idx_reg,  run_idx_next;
    logic [COL_W-1:0]     lit_pos_reg,  lit_pos_next;
    logic [LEN_W-1:0]     lit_left_reg, lit_left_next;
    logic [ROW_W-1:0]     row_cnt_reg,  row_cnt_next;
    logic [OFS_W-1:0]     ofs_reg,      ofs_next;
    logic                 opaque_reg,   opaque_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [OFS_W-1:0]     out_ofs_reg,  out_ofs_next;
    logic                 out_last_reg, out_last_next;
    logic [OFS_W-1:0]     out_plen_reg, out_plen_next;
    logic                 out_free;
    logic                 last_row;
    logic [RUNS_W-1:0]    run_idx_inc;

    assign out_free    = !out_valid_reg || m_ready;
    assign last_row    = (row_cnt_reg == ROW_W'(TILE_H - 1));
    assign run_idx_inc = run_idx_reg + RUNS_W'(1);

    assign m_valid  = out_valid_reg;
    assign m_byte   = out_byte_reg;
    assign m_offset = out_ofs_reg;
    assign m_last   = out_last_reg;
    assign m_plen   = out_plen_reg;

    // Sequence one row: run count, then skip, length and literals of each run; the last row ends with the header
    always_comb
    begin
        state_next     = state_reg;
        run_idx_next   = run_idx_reg;
        lit_pos_next   = lit_pos_reg;
        lit_left_next  = lit_left_reg;
        row_cnt_next   = row_cnt_reg;
        ofs_next       = ofs_reg;
        opaque_next    = opaque_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_ofs_next   = out_ofs_reg;
        out_last_next  = out_last_reg;
        out_plen_next  = out_plen_reg;
        tab_rd_en      = 1'b0;
        tab_raddr      = run_idx_reg[RUN_IDX_W-1:0];
        row_rd_en      = 1'b0;
        row_raddr      = lit_pos_reg;
        row_release    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (row_info.full)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = BYTE_W'(row_info.runs);
                    out_ofs_next   = ofs_reg;
                    out_last_next  = 1'b0;
                    out_plen_next  = '0;
                    ofs_next       = ofs_reg + OFS_W'(1);
                    run_idx_next   = '0;
                    if (row_info.runs == '0)
                    begin
                        state_next = S_ROWEND;
                    end
                    else
                    begin
                        opaque_next = 1'b1;
                        tab_rd_en   = 1'b1;
                        tab_raddr   = '0;
                        state_next  = S_SKIP;
                    end
                end
            end
            S_SKIP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = BYTE_W'(tab_rdata.skip);
                    out_ofs_next   = ofs_reg;
                    out_last_next  = 1'b0;
                    out_plen_next  = '0;
                    ofs_next       = ofs_reg + OFS_W'(1);
                    state_next     = S_LEN;
                end
            end
            S_LEN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = BYTE_W'(tab_rdata.len);
                    out_ofs_next   = ofs_reg;
                    out_last_next  = 1'b0;
                    out_plen_next  = '0;
                    ofs_next       = ofs_reg + OFS_W'(1);
                    row_rd_en      = 1'b1;
                    row_raddr      = tab_rdata.start;
                    lit_pos_next   = tab_rdata.start;
                    lit_left_next  = tab_rdata.len;
                    state_next     = S_LIT;
                end
            end
            S_LIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = row_rdata;
                    out_ofs_next   = ofs_reg;
                    out_last_next  = 1'b0;
                    out_plen_next  = '0;
                    ofs_next       = ofs_reg + OFS_W'(1);
                    if (lit_left_reg > LEN_W'(1))
                    begin
                        // Fetch the next literal while this one goes out
                        row_rd_en     = 1'b1;
                        row_raddr     = lit_pos_reg + COL_W'(1);
                        lit_pos_next  = lit_pos_reg + COL_W'(1);
                        lit_left_next = lit_left_reg - LEN_W'(1);
                    end
                    else
                    begin
                        run_idx_next = run_idx_inc;
                        if (run_idx_inc < row_info.runs)
                        begin
                            tab_rd_en  = 1'b1;
                            tab_raddr  = run_idx_inc[RUN_IDX_W-1:0];
                            state_next = S_SKIP;
                        end
                        else
                        begin
                            state_next = S_ROWEND;
                        end
                    end
                end
            end
            S_ROWEND:
            begin
                if (!last_row)
                begin
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
                    row_release  = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (out_free)
                begin
                    // Header at offset zero closes the tile
                    out_valid_next = 1'b1;
                    out_byte_next  = opaque_reg ? HDR_OPAQUE : HDR_EMPTY;
                    out_ofs_next   = '0;
                    out_last_next  = 1'b1;
                    out_plen_next  = opaque_reg ? ofs_reg : OFS_W'(1);
                    row_cnt_next   = '0;
                    ofs_next       = OFS_W'(1);
                    opaque_next    = 1'b0;
                    row_release    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_idx_reg   <= '0;
            lit_pos_reg   <= '0;
            lit_left_reg  <= '0;
            row_cnt_reg   <= '0;
            ofs_reg       <= OFS_W'(1);
            opaque_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_ofs_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_plen_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            run_idx_reg   <= run_idx_next;
            lit_pos_reg   <= lit_pos_next;
            lit_left_reg  <= lit_left_next;
            row_cnt_reg   <= row_cnt_next;
            ofs_reg       <= ofs_next;
            opaque_reg    <= opaque_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_ofs_reg   <= out_ofs_next;
            out_last_reg  <= out_last_next;
            out_plen_reg  <= out_plen_next;
        end
    end

    `TRLP_ASSERT_NOW(a_busy_needs_row, state_reg != S_IDLE, row_info.full,
        "emitter busy without a held row")
    `TRLP_ASSERT_NOW(a_lit_pending, state_reg == S_LIT, lit_left_reg != '0,
        "literal state with no literal left")
    `TRLP_ASSERT_NOW(a_run_in_range,
        state_reg == S_SKIP || state_reg == S_LEN || state_reg == S_LIT,
        run_idx_reg < row_info.runs, "run index beyond the row's run count")
    `TRLP_ASSERT_NEXT(a_tile_restart, state_reg == S_ROWEND && last_row && out_free,
        ofs_reg == OFS_W'(1) && !opaque_reg && row_cnt_reg == '0,
        "tile counters not restored after the header")

endmodule
